>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define LCT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/lct_pkg.sv
// ---------------------------------------------------------------------------
// lct_pkg
// Types and constants of the linked chain table.
// ---------------------------------------------------------------------------
package lct_pkg;

    localparam int ELEM_W       = 6;
    localparam int LINK_W       = 7;
    localparam int KIND_W       = 2;
    localparam int NUM_CARS_DEF = 64;
    localparam int Q_DEPTH      = 2;

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(64);

    typedef enum logic [KIND_W-1:0] {
        KIND_CONNECT    = 2'd0,
        KIND_DISCONNECT = 2'd1,
        KIND_QUERY      = 2'd2
    } kind_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_POP,
        ST_SELF,
        ST_SUCC
    } state_e;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ELEM_W-1:0] first_elem;
        logic [ELEM_W-1:0] second_elem;
    } item_t;

    typedef struct packed {
        logic [ELEM_W-1:0] elem;
        logic [ELEM_W-1:0] position;
        logic              last;
    } result_t;

    typedef struct packed {
        kind_e             kind;
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

endpackage

>>> hw/rtl/lct_ram.sv
// ---------------------------------------------------------------------------
// lct_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/lct_front.sv
// ---------------------------------------------------------------------------
// lct_front
// Accepts items, drops those that do nothing, queues the rest as commands.
// ---------------------------------------------------------------------------
module lct_front
    import lct_pkg::*;
#(
    parameter int NUM_CARS = NUM_CARS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output q_head_t head,
    input  logic    pop
);

    localparam int QPTR_W = $clog2(Q_DEPTH);
    localparam int QCNT_W = $clog2(Q_DEPTH + 1);

    cmd_t              ent_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    logic a_ok, b_ok, keep, push;
    cmd_t cmd;

    // An element beyond the table makes the item a no-op (a query checks only its first element)
    assign a_ok = {1'b0, item.first_elem}  < LINK_W'(NUM_CARS);
    assign b_ok = {1'b0, item.second_elem} < LINK_W'(NUM_CARS);

    always_comb
    begin
        keep     = 1'b0;
        cmd.kind = KIND_QUERY;
        cmd.a    = item.first_elem;
        cmd.b    = item.second_elem;
        unique case (item.kind)
            KIND_CONNECT:
            begin
                keep     = a_ok && b_ok;
                cmd.kind = KIND_CONNECT;
            end
            KIND_DISCONNECT:
            begin
                keep     = a_ok && b_ok;
                cmd.kind = KIND_DISCONNECT;
            end
            KIND_QUERY:
            begin
                keep     = a_ok;
                cmd.kind = KIND_QUERY;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign busy = (cnt_reg == QCNT_W'(Q_DEPTH));
    assign push = start && !busy && keep;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= cmd;
        end
    end

    assign head.valid = (cnt_reg != '0);
    assign head.cmd   = ent_reg[rptr_reg];

endmodule

>>> hw/rtl/lct_back.sv
// ---------------------------------------------------------------------------
// lct_back
// Carries out queued commands: link writes, and chain walks that emit results.
// ---------------------------------------------------------------------------
module lct_back
    import lct_pkg::*;
#(
    parameter int NUM_CARS = NUM_CARS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  q_head_t head,
    output logic    pop,
    output logic    result_valid,
    output result_t result
);

    localparam int AW    = $clog2(NUM_CARS);
    localparam int CNT_W = $clog2(NUM_CARS + 1);

    state_e state_reg, state_next;

    logic [ELEM_W-1:0] a_reg, a_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ELEM_W-1:0] pend_elem_reg, pend_elem_next;
    logic [ELEM_W-1:0] pend_pos_reg, pend_pos_next;
    logic              res_valid_reg, res_valid_next;
    result_t           res_reg, res_next;

    logic [NUM_CARS-1:0] f_vld_reg, r_vld_reg;
    logic                f_vq_reg, r_vq_reg;

    logic              f_we, r_we, s_we, f_re, r_re, s_re;
    logic [AW-1:0]     f_waddr, r_waddr, s_waddr, f_raddr, r_raddr, s_raddr;
    logic [LINK_W-1:0] f_wdata, r_wdata, f_rdata, r_rdata;
    logic [ELEM_W-1:0] s_wdata, s_rdata;
    logic [LINK_W-1:0] f_link, r_link;
    logic              pred_more, succ_more;

    lct_ram #(.WIDTH(LINK_W), .DEPTH(NUM_CARS)) u_front_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .re    (f_re),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    lct_ram #(.WIDTH(LINK_W), .DEPTH(NUM_CARS)) u_rear_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .re    (r_re),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    // Predecessors found on the way to the head, read back in reverse
    lct_ram #(.WIDTH(ELEM_W), .DEPTH(NUM_CARS)) u_stack_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    // An entry never written since reset reads as null
    assign f_link = f_vq_reg ? f_rdata : LINK_NULL;
    assign r_link = r_vq_reg ? r_rdata : LINK_NULL;

    assign pred_more = (f_link < LINK_W'(NUM_CARS)) && (ptr_reg < AW'(NUM_CARS - 1));
    assign succ_more = (r_link < LINK_W'(NUM_CARS)) && (cnt_reg < CNT_W'(NUM_CARS));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid && head.cmd.kind == KIND_QUERY)
                begin
                    state_next = ST_PRED;
                end
            end
            ST_PRED:
            begin
                if (!pred_more)
                begin
                    state_next = (ptr_reg != '0) ? ST_POP : ST_SELF;
                end
            end
            ST_POP:
            begin
                if (ptr_reg == '0)
                begin
                    state_next = ST_SELF;
                end
            end
            ST_SELF:
            begin
                state_next = ST_SUCC;
            end
            ST_SUCC:
            begin
                if (!succ_more)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop            = 1'b0;
        f_we           = 1'b0;
        r_we           = 1'b0;
        s_we           = 1'b0;
        f_re           = 1'b0;
        r_re           = 1'b0;
        s_re           = 1'b0;
        f_waddr        = head.cmd.b[AW-1:0];
        r_waddr        = head.cmd.a[AW-1:0];
        f_wdata        = LINK_NULL;
        r_wdata        = LINK_NULL;
        s_waddr        = ptr_reg;
        s_wdata        = f_link[ELEM_W-1:0];
        f_raddr        = f_link[AW-1:0];
        r_raddr        = r_link[AW-1:0];
        s_raddr        = ptr_reg - 1'b1;
        a_next         = a_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        pend_elem_next = pend_elem_reg;
        pend_pos_next  = pend_pos_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    unique case (head.cmd.kind)
                        KIND_CONNECT:
                        begin
                            f_we    = 1'b1;
                            r_we    = 1'b1;
                            f_wdata = {1'b0, head.cmd.a};
                            r_wdata = {1'b0, head.cmd.b};
                        end
                        KIND_DISCONNECT:
                        begin
                            f_we = 1'b1;
                            r_we = 1'b1;
                        end
                        KIND_QUERY:
                        begin
                            f_re     = 1'b1;
                            f_raddr  = head.cmd.a[AW-1:0];
                            a_next   = head.cmd.a;
                            ptr_next = '0;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_PRED:
            begin
                cnt_next = '0;
                if (pred_more)
                begin
                    // push the predecessor and follow its front link
                    s_we     = 1'b1;
                    f_re     = 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                end
                else if (ptr_reg != '0)
                begin
                    s_re     = 1'b1;
                    ptr_next = ptr_reg - 1'b1;
                end
            end
            ST_POP:
            begin
                res_valid_next    = 1'b1;
                res_next.elem     = s_rdata;
                res_next.position = ELEM_W'(cnt_reg);
                res_next.last     = 1'b0;
                cnt_next          = cnt_reg + 1'b1;
                if (ptr_reg != '0)
                begin
                    s_re     = 1'b1;
                    ptr_next = ptr_reg - 1'b1;
                end
            end
            ST_SELF:
            begin
                // hold the queried element until its rear link tells if it is last
                pend_elem_next = a_reg;
                pend_pos_next  = ELEM_W'(cnt_reg);
                cnt_next       = cnt_reg + 1'b1;
                r_re           = 1'b1;
                r_raddr        = a_reg[AW-1:0];
            end
            ST_SUCC:
            begin
                res_valid_next    = 1'b1;
                res_next.elem     = pend_elem_reg;
                res_next.position = pend_pos_reg;
                res_next.last     = !succ_more;
                if (succ_more)
                begin
                    pend_elem_next = r_link[ELEM_W-1:0];
                    pend_pos_next  = ELEM_W'(cnt_reg);
                    cnt_next       = cnt_reg + 1'b1;
                    r_re           = 1'b1;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            f_vld_reg     <= '0;
            r_vld_reg     <= '0;
            f_vq_reg      <= 1'b0;
            r_vq_reg      <= 1'b0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            if (f_we)
            begin
                f_vld_reg[f_waddr] <= 1'b1;
            end
            if (r_we)
            begin
                r_vld_reg[r_waddr] <= 1'b1;
            end
            if (f_re)
            begin
                f_vq_reg <= f_vld_reg[f_raddr];
            end
            if (r_re)
            begin
                r_vq_reg <= r_vld_reg[r_raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        pend_elem_reg <= pend_elem_next;
        pend_pos_reg  <= pend_pos_next;
        res_reg       <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

>>> hw/rtl/linked_chain_table_top.sv
// ---------------------------------------------------------------------------
// linked_chain_table_top
// Doubly linked table of elements with connect, disconnect and chain query.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy rises only when
// the two-entry command queue is full. Connect and disconnect are done in
// the idle state of the back end. The pace of a query is set by the single
// read port of the link and stack memories: one step of the walk per cycle
// towards the head, one per cycle back through the stack, one per cycle
// towards the tail. Results come out one per cycle, with a pause before
// the queried element, on result with result_valid high for that cycle
// only, from head to tail; the receiver cannot hold them off, so every
// strobe must be taken. Out-of-range elements and unknown kinds produce
// nothing. Links read as null after reset; no clearing pass is needed.
// ---------------------------------------------------------------------------
module linked_chain_table_top
    import lct_pkg::*;
#(
    parameter int NUM_CARS = NUM_CARS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    result_valid,
    output result_t result
);

    q_head_t head;
    logic    pop;

    lct_front #(.NUM_CARS(NUM_CARS)) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .item  (item),
        .head  (head),
        .pop   (pop)
    );

    lct_back #(.NUM_CARS(NUM_CARS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

>>> hw/rtl/lct_checker.sv
// ---------------------------------------------------------------------------
// lct_checker
// Port-level checks on the linked chain table, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lct_checker
    import lct_pkg::*;
#(
    parameter int NUM_CARS = NUM_CARS_DEF
) (
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    result_valid,
    input result_t result
);

    // a chain never spans more positions than the table has elements
    `LCT_ASSERT_IMP(a_pos_range, clk, rst_n, result_valid, result.position <= ELEM_W'(NUM_CARS - 1))

    // the tail ends a run: the next query cannot emit in the following cycle
    `LCT_ASSERT_NXT(a_gap_after_last, clk, rst_n, result_valid && result.last, !result_valid)

    // busy only rises after an item was taken
    `LCT_ASSERT_IMP(a_busy_cause, clk, rst_n, $rose(busy), $past(start))

    // a beat at the table's final position always closes the chain
    `LCT_ASSERT_IMP(a_last_at_cap, clk, rst_n, result_valid && result.position == ELEM_W'(NUM_CARS - 1), result.last)

endmodule

bind linked_chain_table_top lct_checker #(.NUM_CARS(NUM_CARS)) u_lct_checker (.*);
